// ===== design/vtdi_pkg.sv =====
// Package for the vertex tuple dedup indexer: sizes, key type, state codes.
// No dependencies.
package vtdi_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W = 1 + 8 * 32;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [AW-1:0] addr_t;
    typedef logic [CW-1:0] count_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP
    } state_t;

    // Negative zero folds onto positive zero.
    function automatic logic [31:0] canon(input logic [31:0] b);
        return (b == 32'h8000_0000) ? 32'h0 : b;
    endfunction

endpackage

// ===== design/vtdi_ram.sv =====
// Generic single port RAM with registered read.
// No dependencies.
module vtdi_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] addr,
    input  logic [W-1:0]         wdata,
    output logic [W-1:0]         rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== design/vertex_tuple_dedup_indexer.sv =====
// Top level of the vertex tuple dedup indexer: sequencer and tuple table.
// Depends on vtdi_pkg and vtdi_ram.
//
// channel | dir | handshake       | beat
// command | in  | start / busy    | start_mesh, has_uv, position, uv, normal
// result  | out | done (1 cycle)  | vertex_index, is_new, overflow
//
// The table is scanned linearly through the single RAM port, each entry in a
// read state and then a compare state. The done strobe reports a new tuple or
// overflow once the scan reaches the fill count, a match from that entry's compare.
// Reset empties the table by clearing the fill count; no clearing pass.
// busy is high from acceptance through the done cycle; done cannot be held.
module vertex_tuple_dedup_indexer
    import vtdi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        start_mesh,
    input  logic        has_uv,
    input  logic [31:0] position_x,
    input  logic [31:0] position_y,
    input  logic [31:0] position_z,
    input  logic [31:0] uv_u,
    input  logic [31:0] uv_v,
    input  logic [31:0] normal_x,
    input  logic [31:0] normal_y,
    input  logic [31:0] normal_z,
    output logic        done,
    output logic [11:0] vertex_index,
    output logic        is_new,
    output logic        overflow
);
    state_t state_reg, state_next;
    count_t count_reg, count_next;
    count_t scan_reg, scan_next;
    key_t   key_reg;
    logic   done_reg, done_next;
    logic [11:0] idx_reg, idx_next;
    logic   new_reg, new_next, ovf_reg, ovf_next;
    logic   we;
    addr_t  addr;
    key_t   rdata;
    logic   uvsel;

    assign uvsel = has_uv;

    // Canonical key capture
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            key_reg <= {uvsel, canon(position_x), canon(position_y), canon(position_z),
                        uvsel ? canon(uv_u) : 32'h0, uvsel ? canon(uv_v) : 32'h0,
                        canon(normal_x), canon(normal_y), canon(normal_z)};
        end
    end

    vtdi_ram #(.W(KEY_W), .D(TABLE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (key_reg),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            scan_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            scan_reg  <= scan_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        new_reg <= new_next;
        ovf_reg <= ovf_next;
    end

    // Scan sequencer: read entry scan, compare it in the next cycle; append or flag full at the fill count
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        scan_next  = scan_reg;
        done_next  = 1'b0;
        idx_next   = idx_reg;
        new_next   = new_reg;
        ovf_next   = ovf_reg;
        we         = 1'b0;
        addr       = scan_reg[AW-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                // no accept during the done cycle
                if (start && !busy)
                begin
                    if (start_mesh)
                    begin
                        count_next = '0;
                    end
                    scan_next  = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (scan_reg >= count_reg)
                begin
                    // Not found: append or flag full
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                    new_next   = 1'b0;
                    ovf_next   = 1'b0;
                    idx_next   = '0;
                    if (count_reg == count_t'(TABLE_DEPTH))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        we         = 1'b1;
                        new_next   = 1'b1;
                        idx_next   = 12'(count_reg);
                        count_next = count_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (rdata == key_reg)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                    idx_next   = 12'(scan_reg);
                    new_next   = 1'b0;
                    ovf_next   = 1'b0;
                end
                else
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != ST_IDLE) || done_reg;
    assign done         = done_reg;
    assign vertex_index = idx_reg;
    assign is_new       = new_reg;
    assign overflow     = ovf_reg;
endmodule

// ===== design/vtdi_checker.sv =====
// Port-level checks for the vertex tuple dedup indexer, bound to the top.
// Depends on vertex_tuple_dedup_indexer.
module vtdi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [11:0] vertex_index,
    input logic        is_new,
    input logic        overflow
);
    // A result never claims both new and overflow
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(is_new && overflow))
        else $error("is_new and overflow together");

    // Overflow reports index zero
    a_ovf_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (done && overflow) |-> (vertex_index == 12'h0))
        else $error("overflow with nonzero index");

    // Accepted command makes the block busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("not busy after accept");

    // Results are single-cycle strobes
    a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held two cycles");
endmodule

bind vertex_tuple_dedup_indexer vtdi_checker u_vtdi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .vertex_index (vertex_index),
    .is_new       (is_new),
    .overflow     (overflow)
);
